// ===== hdl/matrix_keypad_debounce_scanner_top_assert.svh =====
// Assertion macros used by the keypad scanner port checker.
`ifndef MATRIX_KEYPAD_DEBOUNCE_SCANNER_TOP_ASSERT_SVH
`define MATRIX_KEYPAD_DEBOUNCE_SCANNER_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define MKDS_AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keypad scanner check failed");

// Consequent holds in the cycle after the antecedent.
`define MKDS_AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keypad scanner check failed");

// Consequent is checked after a delay from the antecedent.
`define MKDS_AST_DLY2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
        else $error("keypad scanner check failed");

// Reset check with no disable condition.
`define MKDS_AST_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("keypad scanner reset check failed");

`endif

// ===== hdl/mkds_pkg.sv =====
// Types and constants of the keypad debounce scanner.
package mkds_pkg;

    localparam int NUM_KEYS    = 12;
    localparam int LINE_COUNT  = 6;
    localparam int KEY_IDX_W   = 4;
    localparam int DEB_W       = 8;
    localparam int NOW_W       = 32;
    localparam int OUT_CNT_W   = 16;
    localparam int KIND_W      = 2;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 56;

    localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd10;

    // Item kinds carried on tuser; the unused code acts as a query.
    typedef enum logic [KIND_W-1:0] {
        KIND_SCAN  = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    // Button line and scan half of each key (key = row*4 + column).
    localparam logic [2:0] KEY_LINE [NUM_KEYS] = '{
        3'd0, 3'd1, 3'd0, 3'd1,
        3'd2, 3'd3, 3'd2, 3'd3,
        3'd4, 3'd5, 3'd4, 3'd5
    };
    localparam logic KEY_HALF [NUM_KEYS] = '{
        1'b0, 1'b0, 1'b1, 1'b1,
        1'b0, 1'b0, 1'b1, 1'b1,
        1'b0, 1'b0, 1'b1, 1'b1
    };

    // Per-key command for one beat.
    typedef struct packed {
        logic scan;
        logic frame;
        logic down;
    } t_key_cmd;

    // Per-key flags after the beat's update.
    typedef struct packed {
        logic held;
        logic pressed;
        logic released;
    } t_key_stat;

endpackage

// ===== hdl/matrix_keypad_debounce_scanner_top.sv =====
// Top level of the 12-key debounced keypad scanner.
// Path: an accepted beat passes the input register, then the result register that drives o_m_tvalid.
// Throughput: one beat per cycle while the result is not stalled; the twelve key cells update in parallel.
// Backpressure: input register and result register each hold one beat; ready
// falls only while both are full and the result is not taken.
// Reset (synchronous, active low) clears all key state, both valid flags and
// sets the debounce hold-off to 10 ms.
module matrix_keypad_debounce_scanner_top #(
    parameter int COUNT_WIDTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [mkds_pkg::DEB_W-1:0]        i_cfg_wr_data,  // debounce_ms
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: half[0], button_levels[6:1], now_ms[38:7], key_index[42:39], zero fill
    input  logic [mkds_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // tuser: kind[1:0]
    input  logic [mkds_pkg::KIND_W-1:0]       i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: held_mask[11:0], pressed_mask[23:12], released_mask[35:24],
    //        frames_held[51:36], zero fill
    output logic [mkds_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    logic [mkds_pkg::DEB_W-1:0]       r_debounce;
    logic                             r_in_valid;
    logic [mkds_pkg::KIND_W-1:0]      r_kind;
    logic                             r_half;
    logic [mkds_pkg::LINE_COUNT-1:0]  r_levels;
    logic [TIME_WIDTH-1:0]            r_now;
    logic [mkds_pkg::KEY_IDX_W-1:0]   r_key_index;
    logic                             r_out_valid;
    logic [mkds_pkg::NUM_KEYS-1:0]    r_held_mask;
    logic [mkds_pkg::NUM_KEYS-1:0]    r_pressed_mask;
    logic [mkds_pkg::NUM_KEYS-1:0]    r_released_mask;
    logic [mkds_pkg::OUT_CNT_W-1:0]   r_frames_held;

    logic                             in_fire;
    logic                             out_free;
    logic                             work;
    logic                             do_scan;
    logic                             do_frame;
    mkds_pkg::t_key_cmd               key_cmd  [mkds_pkg::NUM_KEYS];
    mkds_pkg::t_key_stat              key_stat [mkds_pkg::NUM_KEYS];
    logic [COUNT_WIDTH-1:0]           key_count [mkds_pkg::NUM_KEYS];
    logic [mkds_pkg::NUM_KEYS-1:0]    held_mask;
    logic [mkds_pkg::NUM_KEYS-1:0]    pressed_mask;
    logic [mkds_pkg::NUM_KEYS-1:0]    released_mask;
    logic [mkds_pkg::OUT_CNT_W-1:0]   frames_held;

    // Handshake: the input stage moves on whenever the result register can take it.
    assign out_free   = !r_out_valid || i_m_tready;
    assign work       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign in_fire    = i_s_tvalid && o_s_tready;

    // Debounce register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= mkds_pkg::DEBOUNCE_RST;
        end else if (i_cfg_wr_en) begin
            r_debounce <= i_cfg_wr_data;
        end
    end

    // Input register: valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (work) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register: payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind      <= i_s_tuser;
            r_half      <= i_s_tdata[0];
            r_levels    <= i_s_tdata[6:1];
            r_now       <= i_s_tdata[7 +: TIME_WIDTH];
            r_key_index <= i_s_tdata[42:39];
        end
    end

    // Decode the beat's kind; the spare code changes nothing.
    always_comb begin
        do_scan  = 1'b0;
        do_frame = 1'b0;
        case (mkds_pkg::t_kind'(r_kind))
            mkds_pkg::KIND_SCAN:  do_scan  = work;
            mkds_pkg::KIND_FRAME: do_frame = work;
            mkds_pkg::KIND_QUERY: ;
            default: ;
        endcase
    end

    // Key cells, one per key.
    generate
        for (genvar k = 0; k < mkds_pkg::NUM_KEYS; k++) begin : g_key
            assign key_cmd[k].scan  = do_scan && (r_half == mkds_pkg::KEY_HALF[k]);
            assign key_cmd[k].frame = do_frame;
            assign key_cmd[k].down  = !r_levels[mkds_pkg::KEY_LINE[k]];

            mkds_key_cell #(
                .COUNT_WIDTH (COUNT_WIDTH),
                .TIME_WIDTH  (TIME_WIDTH)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (key_cmd[k]),
                .i_now      (r_now),
                .i_debounce (r_debounce),
                .o_stat     (key_stat[k]),
                .o_count    (key_count[k])
            );

            assign held_mask[k]     = key_stat[k].held;
            assign pressed_mask[k]  = key_stat[k].pressed;
            assign released_mask[k] = key_stat[k].released;
        end
    endgenerate

    // Requested key's count.
    mkds_count_sel #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count_sel (
        .i_counts      (key_count),
        .i_key_index   (r_key_index),
        .o_frames_held (frames_held)
    );

    // Result register: valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (work) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register: payload.
    always_ff @(posedge i_clk) begin
        if (work) begin
            r_held_mask     <= held_mask;
            r_pressed_mask  <= pressed_mask;
            r_released_mask <= released_mask;
            r_frames_held   <= frames_held;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_frames_held, r_released_mask, r_pressed_mask, r_held_mask};

endmodule

// ===== hdl/mkds_key_cell.sv =====
// One key: debounce stamp, held and edge flags, saturating held-frame counter.
module mkds_key_cell #(
    parameter int COUNT_WIDTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mkds_pkg::t_key_cmd           i_cmd,
    input  logic [TIME_WIDTH-1:0]        i_now,
    input  logic [mkds_pkg::DEB_W-1:0]   i_debounce,
    output mkds_pkg::t_key_stat          o_stat,
    output logic [COUNT_WIDTH-1:0]       o_count
);

    logic [TIME_WIDTH-1:0]  r_stamp,  n_stamp;
    logic [COUNT_WIDTH-1:0] r_count,  n_count;
    logic                   r_held,   n_held;
    logic                   r_last,   n_last;
    logic                   r_pressed, n_pressed;
    logic                   r_released, n_released;
    logic [TIME_WIDTH-1:0]  elapsed;
    logic                   hold_off_done;

    // Wrapping age of the last pressed sample.
    assign elapsed       = i_now - r_stamp;
    assign hold_off_done = elapsed >= {{(TIME_WIDTH-mkds_pkg::DEB_W){1'b0}}, i_debounce};

    // Next state of the key.
    always_comb begin
        n_stamp    = r_stamp;
        n_count    = r_count;
        n_held     = r_held;
        n_last     = r_last;
        n_pressed  = r_pressed;
        n_released = r_released;
        if (i_cmd.scan) begin
            if (i_cmd.down) begin
                n_stamp = i_now;
                n_held  = 1'b1;
                if (!r_last) begin
                    n_pressed = 1'b1;
                end
            end else if (hold_off_done) begin
                n_held  = 1'b0;
                n_count = '0;
                if (r_last) begin
                    n_released = 1'b1;
                end
            end
        end else if (i_cmd.frame) begin
            n_last     = r_held;
            n_pressed  = 1'b0;
            n_released = 1'b0;
            if (r_held) begin
                if (r_count != {COUNT_WIDTH{1'b1}}) begin
                    n_count = r_count + 1'b1;
                end
            end else begin
                n_count = '0;
            end
        end
    end

    // Hold the key state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp    <= '0;
            r_count    <= '0;
            r_held     <= 1'b0;
            r_last     <= 1'b0;
            r_pressed  <= 1'b0;
            r_released <= 1'b0;
        end else begin
            r_stamp    <= n_stamp;
            r_count    <= n_count;
            r_held     <= n_held;
            r_last     <= n_last;
            r_pressed  <= n_pressed;
            r_released <= n_released;
        end
    end

    // Report the state after this beat.
    assign o_stat.held     = n_held;
    assign o_stat.pressed  = n_pressed;
    assign o_stat.released = n_released;
    assign o_count         = n_count;

endmodule

// ===== hdl/mkds_count_sel.sv =====
// Pick the requested key's held-frame count and saturate it to the report width.
module mkds_count_sel #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic [COUNT_WIDTH-1:0]            i_counts [mkds_pkg::NUM_KEYS],
    input  logic [mkds_pkg::KEY_IDX_W-1:0]    i_key_index,
    output logic [mkds_pkg::OUT_CNT_W-1:0]    o_frames_held
);

    logic [COUNT_WIDTH-1:0]          sel_count;
    logic [mkds_pkg::OUT_CNT_W-1:0]  fit_count;

    // Out-of-range keys report zero.
    always_comb begin
        if (i_key_index < mkds_pkg::KEY_IDX_W'(mkds_pkg::NUM_KEYS)) begin
            sel_count = i_counts[i_key_index];
        end else begin
            sel_count = '0;
        end
    end

    // Fit the count into the report width.
    generate
        if (COUNT_WIDTH > mkds_pkg::OUT_CNT_W) begin : g_sat
            assign fit_count = (|sel_count[COUNT_WIDTH-1:mkds_pkg::OUT_CNT_W]) ?
                               {mkds_pkg::OUT_CNT_W{1'b1}} :
                               sel_count[mkds_pkg::OUT_CNT_W-1:0];
        end else begin : g_ext
            assign fit_count = mkds_pkg::OUT_CNT_W'(sel_count);
        end
    endgenerate

    assign o_frames_held = fit_count;

endmodule

// ===== hdl/mkds_port_checker.sv =====
// Port-level checks of the keypad scanner, bound to its top level.
`include "matrix_keypad_debounce_scanner_top_assert.svh"

module mkds_port_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [mkds_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    // A stalled result beat stays put.
    `MKDS_AST_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // A key cannot be both newly pressed and newly released within one frame.
    `MKDS_AST_SAME(a_flags_disjoint, i_clk, i_rst_n, o_m_tvalid, (o_m_tdata[23:12] & o_m_tdata[35:24]) == 12'd0)

    // An accepted beat is followed by a result waiting, after the input and result registers.
    `MKDS_AST_DLY2(a_accept_result, i_clk, i_rst_n, i_s_tvalid && o_s_tready, o_m_tvalid)

    // Reset empties the result register.
    `MKDS_AST_RST(a_reset_empty, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

bind matrix_keypad_debounce_scanner_top mkds_port_checker u_port_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
